// ----- design/event_latch_transition_unit_defines.svh -----
// Assertion macros for the event latch transition unit.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef EVENT_LATCH_TRANSITION_UNIT_DEFINES_SVH
`define EVENT_LATCH_TRANSITION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ELT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ELT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ELT_ASSERT_IMPL(label, ante, cons)
`define ELT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/elt_pkg.sv -----
// Shared types and codes for the event latch transition unit.
// No dependencies; used by elt_next_state and the top level.
package elt_pkg;

  typedef enum logic [1:0] {
    OPC_DEC = 2'd0,
    OPC_INC = 2'd1,
    OPC_PUB = 2'd2,
    OPC_DEP = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRING = 2'd1,
    PH_FIRED  = 2'd2,
    PH_UNUSED = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_FIRE    = 3'd1,
    ACT_DRAIN   = 3'd2,
    ACT_PARK    = 3'd3,
    ACT_DELIVER = 3'd4
  } action_e;

  // Status part of one transition result.
  typedef struct packed {
    phase_e  phase;
    logic    destroyed;
    action_e action;
    logic    destroy_request;
  } elt_status_t;

  localparam int unsigned StatusWidth = $bits(elt_status_t);

endpackage

// ----- design/elt_pipe_reg.sv -----
// One valid/stall register stage holding an opaque payload.
// No dependencies; used twice by the top level.
module elt_pipe_reg #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q;
  logic             valid_d;
  logic [Width-1:0] data_q;
  logic             load;

  // The stage can take a new transaction when empty or when its content leaves.
  assign stall_o = valid_q && stall_i;
  assign load    = valid_i && !stall_o;
  assign valid_d = load || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- design/elt_next_state.sv -----
// Next-state decision for one event word: opcode handling and destroy edge.
// Depends on elt_pkg.
module elt_next_state #(
  parameter int unsigned LatchWidth    = 32,
  parameter int unsigned ConsumerWidth = 29
) (
  input  elt_pkg::opcode_e         opcode_i,
  input  logic [LatchWidth-1:0]    latch_i,
  input  logic [ConsumerWidth-1:0] consumers_i,
  input  elt_pkg::phase_e          phase_i,
  input  logic                     destroyed_i,
  input  logic                     is_counted_i,
  input  logic                     destroy_on_fire_i,
  output logic [LatchWidth-1:0]    latch_o,
  output logic [ConsumerWidth-1:0] consumers_o,
  output elt_pkg::elt_status_t     status_o
);

  localparam logic [LatchWidth-1:0]    LatchOne = {{(LatchWidth-1){1'b0}}, 1'b1};
  localparam logic [ConsumerWidth-1:0] ConsOne  = {{(ConsumerWidth-1){1'b0}}, 1'b1};

  logic [LatchWidth-1:0]    latch_dec;
  logic [LatchWidth-1:0]    latch_inc;
  logic [ConsumerWidth-1:0] cons_nxt;
  elt_pkg::phase_e          phase_nxt;
  elt_pkg::action_e         action;
  logic                     edge_hit;

  assign latch_dec = latch_i - LatchOne;
  assign latch_inc = latch_i + LatchOne;

  always_comb begin
    latch_o   = latch_i;
    cons_nxt  = consumers_i;
    phase_nxt = phase_i;
    action    = elt_pkg::ACT_NONE;
    case (opcode_i)
      elt_pkg::OPC_DEC: begin
        if (phase_i != elt_pkg::PH_FIRED) begin
          latch_o = latch_dec;
          if ((latch_dec == '0) && (phase_i == elt_pkg::PH_IDLE)) begin
            phase_nxt = elt_pkg::PH_FIRING;
            action    = elt_pkg::ACT_FIRE;
          end
        end
      end
      elt_pkg::OPC_INC: begin
        if (phase_i != elt_pkg::PH_FIRED) begin
          latch_o = latch_inc;
        end
      end
      elt_pkg::OPC_PUB: begin
        if (phase_i == elt_pkg::PH_FIRING) begin
          phase_nxt = elt_pkg::PH_FIRED;
          action    = elt_pkg::ACT_DRAIN;
        end
      end
      elt_pkg::OPC_DEP: begin
        if (is_counted_i && (consumers_i != '0)) begin
          cons_nxt = consumers_i - ConsOne;
        end
        action = (phase_i == elt_pkg::PH_FIRED) ? elt_pkg::ACT_DELIVER : elt_pkg::ACT_PARK;
      end
      default: begin
        action = elt_pkg::ACT_NONE;
      end
    endcase
  end

  // The destroy edge fires only once, on the first fired word whose condition holds.
  assign edge_hit = !destroyed_i && (phase_nxt == elt_pkg::PH_FIRED) &&
                    (destroy_on_fire_i || (is_counted_i && (cons_nxt == '0)));

  assign consumers_o              = cons_nxt;
  assign status_o.phase           = phase_nxt;
  assign status_o.destroyed       = destroyed_i || edge_hit;
  assign status_o.action          = action;
  assign status_o.destroy_request = edge_hit;

endmodule

// ----- design/event_latch_transition_unit.sv -----
// Top level of the event latch transition unit.
// Depends on elt_pkg, elt_pipe_reg, elt_next_state and the assertion macro header.

// Takes one event word transaction per clock cycle while not stalled and returns one
// result per transaction: the word is captured in an input register, decided in
// one pass of logic, and held in a result register. The throughput of one
// transaction per cycle when not stalled is set by that single decision pass;
// a stalled result register holds its result while the input register can
// still take one more transaction. Nothing is remembered between transactions.
`include "event_latch_transition_unit_defines.svh"

module event_latch_transition_unit #(
  parameter int unsigned LATCH_WIDTH    = 32,
  parameter int unsigned CONSUMER_WIDTH = 29
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       opcode_i,
  input  logic signed [LATCH_WIDTH-1:0]    latch_in_i,
  input  logic [CONSUMER_WIDTH-1:0]        consumers_in_i,
  input  logic [1:0]                       phase_in_i,
  input  logic                             destroyed_in_i,
  input  logic                             is_counted_i,
  input  logic                             destroy_on_fire_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [LATCH_WIDTH-1:0]    latch_out_o,
  output logic [CONSUMER_WIDTH-1:0]        consumers_out_o,
  output logic [1:0]                       phase_out_o,
  output logic                             destroyed_out_o,
  output logic [2:0]                       base_action_o,
  output logic                             destroy_request_o
);

  localparam int unsigned InWidth  = 2 + LATCH_WIDTH + CONSUMER_WIDTH + 2 + 3;
  localparam int unsigned OutWidth = LATCH_WIDTH + CONSUMER_WIDTH + elt_pkg::StatusWidth;

  logic [InWidth-1:0]        in_data;
  logic [InWidth-1:0]        s1_data;
  logic                      s1_valid;
  logic                      s1_stall;
  logic [1:0]                s1_opcode;
  logic [LATCH_WIDTH-1:0]    s1_latch;
  logic [CONSUMER_WIDTH-1:0] s1_cons;
  logic [1:0]                s1_phase;
  logic                      s1_destroyed;
  logic                      s1_counted;
  logic                      s1_on_fire;
  logic [LATCH_WIDTH-1:0]    nxt_latch;
  logic [CONSUMER_WIDTH-1:0] nxt_cons;
  elt_pkg::elt_status_t      nxt_status;
  logic [OutWidth-1:0]       nxt_data;
  logic [OutWidth-1:0]       out_data;
  logic [LATCH_WIDTH-1:0]    out_latch;
  elt_pkg::elt_status_t      out_status;

  assign in_data = {opcode_i, $unsigned(latch_in_i), consumers_in_i, phase_in_i,
                    destroyed_in_i, is_counted_i, destroy_on_fire_i};

  elt_pipe_reg #(
    .Width (InWidth)
  ) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data),
    .valid_o (s1_valid),
    .stall_i (s1_stall),
    .data_o  (s1_data)
  );

  assign {s1_opcode, s1_latch, s1_cons, s1_phase, s1_destroyed, s1_counted, s1_on_fire} =
    s1_data;

  elt_next_state #(
    .LatchWidth    (LATCH_WIDTH),
    .ConsumerWidth (CONSUMER_WIDTH)
  ) u_next_state (
    .opcode_i          (elt_pkg::opcode_e'(s1_opcode)),
    .latch_i           (s1_latch),
    .consumers_i       (s1_cons),
    .phase_i           (elt_pkg::phase_e'(s1_phase)),
    .destroyed_i       (s1_destroyed),
    .is_counted_i      (s1_counted),
    .destroy_on_fire_i (s1_on_fire),
    .latch_o           (nxt_latch),
    .consumers_o       (nxt_cons),
    .status_o          (nxt_status)
  );

  assign nxt_data = {nxt_latch, nxt_cons, nxt_status};

  elt_pipe_reg #(
    .Width (OutWidth)
  ) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .stall_o (s1_stall),
    .data_i  (nxt_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data)
  );

  assign {out_latch, consumers_out_o, out_status} = out_data;
  assign latch_out_o       = $signed(out_latch);
  assign phase_out_o       = out_status.phase;
  assign destroyed_out_o   = out_status.destroyed;
  assign base_action_o     = out_status.action;
  assign destroy_request_o = out_status.destroy_request;

  // A destroy request always comes with a fired, destroyed word.
  `ELT_ASSERT_IMPL(a_req_fired, out_valid_o && destroy_request_o, destroyed_out_o && (phase_out_o == elt_pkg::PH_FIRED))
  // A fire claim leaves the latch at zero and the phase at firing.
  `ELT_ASSERT_IMPL(a_fire_zero, out_valid_o && (base_action_o == elt_pkg::ACT_FIRE), (latch_out_o == '0) && (phase_out_o == elt_pkg::PH_FIRING))
  // A drain is only ever reported for a word that has just become fired.
  `ELT_ASSERT_IMPL(a_drain_fired, out_valid_o && (base_action_o == elt_pkg::ACT_DRAIN), phase_out_o == elt_pkg::PH_FIRED)
  // A decided word that is not held back shows up at the output next cycle.
  `ELT_ASSERT_NEXT(a_advance, s1_valid && !s1_stall, out_valid_o)

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for event_latch_transition_unit.
// Needs elt_pkg and the unit's RTL; a small scoreboard class predicts each
// event word transition and checks the results in order.
localparam int unsigned LatchW = 32;
localparam int unsigned ConsW  = 29;

typedef struct packed {
  elt_pkg::opcode_e   op;
  logic [LatchW-1:0]  latch;
  logic [ConsW-1:0]   consumers;
  elt_pkg::phase_e    phase;
  logic               destroyed;
  logic               counted;
  logic               on_fire;
} event_word_t;

typedef struct packed {
  logic [LatchW-1:0]  latch;
  logic [ConsW-1:0]   consumers;
  logic [1:0]         phase;
  logic               destroyed;
  logic [2:0]         action;
  logic               destroy_req;
} event_update_t;

class event_transition_checker;
  event_update_t expected_updates[$];
  int unsigned   mismatches;

  function event_update_t next_event_word(event_word_t w);
    event_update_t     u;
    logic [LatchW-1:0] lat;
    logic [ConsW-1:0]  cnt;
    elt_pkg::phase_e   ph;
    logic              dst;
    elt_pkg::action_e  act;
    logic              req;
    lat = w.latch;
    cnt = w.consumers;
    ph  = w.phase;
    dst = w.destroyed;
    act = elt_pkg::ACT_NONE;
    req = 1'b0;
    case (w.op)
      elt_pkg::OPC_DEC: begin
        if (ph != elt_pkg::PH_FIRED) begin
          lat = lat - 1'b1;
          if (lat == '0 && ph == elt_pkg::PH_IDLE) begin
            ph  = elt_pkg::PH_FIRING;
            act = elt_pkg::ACT_FIRE;
          end
        end
      end
      elt_pkg::OPC_INC: begin
        if (ph != elt_pkg::PH_FIRED) lat = lat + 1'b1;
      end
      elt_pkg::OPC_PUB: begin
        if (ph == elt_pkg::PH_FIRING) begin
          ph  = elt_pkg::PH_FIRED;
          act = elt_pkg::ACT_DRAIN;
        end
      end
      default: begin
        if (w.counted && cnt != '0) cnt = cnt - 1'b1;
        act = (ph == elt_pkg::PH_FIRED) ? elt_pkg::ACT_DELIVER : elt_pkg::ACT_PARK;
      end
    endcase
    // The destroy edge is taken only once, on the first fired transition.
    if (!dst && ph == elt_pkg::PH_FIRED && (w.on_fire || (w.counted && cnt == '0))) begin
      dst = 1'b1;
      req = 1'b1;
    end
    u.latch       = lat;
    u.consumers   = cnt;
    u.phase       = ph;
    u.destroyed   = dst;
    u.action      = act;
    u.destroy_req = req;
    return u;
  endfunction

  function void note_word(event_word_t w);
    expected_updates.push_back(next_event_word(w));
  endfunction

  function void check_update(event_update_t got);
    event_update_t exp;
    if (expected_updates.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected result transaction: latch=%h cons=%h ph=%0d dst=%0d act=%0d req=%0d",
                 got.latch, got.consumers, got.phase, got.destroyed, got.action,
                 got.destroy_req);
      return;
    end
    exp = expected_updates.pop_front();
    if (got.latch !== exp.latch || got.consumers !== exp.consumers ||
        got.phase !== exp.phase || got.destroyed !== exp.destroyed ||
        got.action !== exp.action || got.destroy_req !== exp.destroy_req) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch expected: latch=%h cons=%h ph=%0d dst=%0d act=%0d req=%0d",
                 exp.latch, exp.consumers, exp.phase, exp.destroyed, exp.action,
                 exp.destroy_req);
        $display("         actual:   latch=%h cons=%h ph=%0d dst=%0d act=%0d req=%0d",
                 got.latch, got.consumers, got.phase, got.destroyed, got.action,
                 got.destroy_req);
      end
    end
  endfunction
endclass

module tb_top;

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              in_valid_i        = 1'b0;
  logic              in_stall_o;
  logic [1:0]        opcode_i          = '0;
  logic [LatchW-1:0] latch_in_i        = '0;
  logic [ConsW-1:0]  consumers_in_i    = '0;
  logic [1:0]        phase_in_i        = '0;
  logic              destroyed_in_i    = 1'b0;
  logic              is_counted_i      = 1'b0;
  logic              destroy_on_fire_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i       = 1'b0;
  logic [LatchW-1:0] latch_out_o;
  logic [ConsW-1:0]  consumers_out_o;
  logic [1:0]        phase_out_o;
  logic              destroyed_out_o;
  logic [2:0]        base_action_o;
  logic              destroy_request_o;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  event_transition_checker checker_h = new();

  event_latch_transition_unit #(
    .LATCH_WIDTH   (LatchW),
    .CONSUMER_WIDTH(ConsW)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .latch_in_i       (latch_in_i),
    .consumers_in_i   (consumers_in_i),
    .phase_in_i       (phase_in_i),
    .destroyed_in_i   (destroyed_in_i),
    .is_counted_i     (is_counted_i),
    .destroy_on_fire_i(destroy_on_fire_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .latch_out_o      (latch_out_o),
    .consumers_out_o  (consumers_out_o),
    .phase_out_o      (phase_out_o),
    .destroyed_out_o  (destroyed_out_o),
    .base_action_o    (base_action_o),
    .destroy_request_o(destroy_request_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Both sides are observed on the pre-edge values, so ordering within the
  // time step does not matter.
  always @(posedge clk_i) begin
    event_word_t   w;
    event_update_t u;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        w.op        = elt_pkg::opcode_e'(opcode_i);
        w.latch     = latch_in_i;
        w.consumers = consumers_in_i;
        w.phase     = elt_pkg::phase_e'(phase_in_i);
        w.destroyed = destroyed_in_i;
        w.counted   = is_counted_i;
        w.on_fire   = destroy_on_fire_i;
        checker_h.note_word(w);
      end
      if (out_valid_o && !out_stall_i) begin
        u.latch       = latch_out_o;
        u.consumers   = consumers_out_o;
        u.phase       = phase_out_o;
        u.destroyed   = destroyed_out_o;
        u.action      = base_action_o;
        u.destroy_req = destroy_request_o;
        checker_h.check_update(u);
      end
    end
  end

  task automatic send_word(input event_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    opcode_i          <= w.op;
    latch_in_i        <= w.latch;
    consumers_in_i    <= w.consumers;
    phase_in_i        <= w.phase;
    destroyed_in_i    <= w.destroyed;
    is_counted_i      <= w.counted;
    destroy_on_fire_i <= w.on_fire;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_fields(input elt_pkg::opcode_e op, input logic [LatchW-1:0] lat,
                             input logic [ConsW-1:0] cnt, input elt_pkg::phase_e ph,
                             input logic dst, input logic counted, input logic on_fire);
    event_word_t w;
    w = '{op, lat, cnt, ph, dst, counted, on_fire};
    send_word(w);
  endtask

  // Latch and count values lean towards the edges where firing, wrapping and
  // saturation happen; full-range values keep every bit toggling.
  function automatic event_word_t random_word();
    event_word_t w;
    w.op = elt_pkg::opcode_e'($urandom_range(3));
    case ($urandom_range(7))
      0:       w.latch = '0;
      1:       w.latch = 1;
      2:       w.latch = '1;
      3:       w.latch = 2;
      4:       w.latch = {1'b0, {(LatchW-1){1'b1}}};
      5:       w.latch = {1'b1, {(LatchW-1){1'b0}}};
      default: w.latch = $urandom;
    endcase
    case ($urandom_range(5))
      0:       w.consumers = '0;
      1:       w.consumers = 1;
      2:       w.consumers = ConsW'($urandom_range(7));
      3:       w.consumers = '1;
      default: w.consumers = ConsW'($urandom);
    endcase
    w.phase     = elt_pkg::phase_e'($urandom_range(3));
    w.destroyed = ($urandom_range(3) == 0);
    w.counted   = 1'($urandom_range(1));
    w.on_fire   = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) send_word(random_word());
  endtask

  localparam logic [LatchW-1:0] LatMax = {1'b0, {(LatchW-1){1'b1}}};
  localparam logic [LatchW-1:0] LatMin = {1'b1, {(LatchW-1){1'b0}}};
  localparam logic [ConsW-1:0]  ConsMax = '1;

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed transactions, no idling.
    send_fields(elt_pkg::OPC_DEC, 1, 0, elt_pkg::PH_IDLE, 0, 0, 0);
    send_fields(elt_pkg::OPC_DEC, 1, 0, elt_pkg::PH_FIRING, 0, 0, 0);
    send_fields(elt_pkg::OPC_DEC, 5, 3, elt_pkg::PH_FIRED, 0, 0, 1);
    send_fields(elt_pkg::OPC_DEC, LatMin, 0, elt_pkg::PH_IDLE, 0, 0, 0);
    send_fields(elt_pkg::OPC_DEC, 0, 0, elt_pkg::PH_IDLE, 0, 0, 0);
    send_fields(elt_pkg::OPC_INC, LatMax, ConsMax, elt_pkg::PH_IDLE, 0, 1, 1);
    send_fields(elt_pkg::OPC_INC, 7, 0, elt_pkg::PH_FIRED, 1, 1, 1);
    send_fields(elt_pkg::OPC_INC, '1, 2, elt_pkg::PH_UNUSED, 0, 1, 1);
    send_fields(elt_pkg::OPC_DEC, 1, 0, elt_pkg::PH_UNUSED, 0, 1, 1);
    send_fields(elt_pkg::OPC_PUB, 0, 4, elt_pkg::PH_FIRING, 0, 0, 1);
    send_fields(elt_pkg::OPC_PUB, 0, 0, elt_pkg::PH_FIRING, 0, 1, 0);
    send_fields(elt_pkg::OPC_PUB, 0, 5, elt_pkg::PH_FIRING, 0, 1, 0);
    send_fields(elt_pkg::OPC_PUB, 0, 0, elt_pkg::PH_IDLE, 0, 1, 1);
    send_fields(elt_pkg::OPC_PUB, 0, 0, elt_pkg::PH_UNUSED, 0, 1, 1);
    send_fields(elt_pkg::OPC_PUB, 0, 0, elt_pkg::PH_FIRING, 1, 1, 1);
    send_fields(elt_pkg::OPC_DEP, 0, 1, elt_pkg::PH_FIRED, 0, 1, 0);
    send_fields(elt_pkg::OPC_DEP, 0, 0, elt_pkg::PH_FIRED, 0, 1, 0);
    send_fields(elt_pkg::OPC_DEP, 3, ConsMax, elt_pkg::PH_IDLE, 0, 0, 0);
    send_fields(elt_pkg::OPC_DEP, 3, ConsMax, elt_pkg::PH_FIRING, 0, 1, 0);
    send_fields(elt_pkg::OPC_DEP, 0, 1, elt_pkg::PH_UNUSED, 0, 1, 1);
    send_fields(elt_pkg::OPC_DEP, 0, 3, elt_pkg::PH_FIRED, 0, 1, 1);
    send_fields(elt_pkg::OPC_DEP, 0, 1, elt_pkg::PH_FIRED, 1, 1, 1);
    send_fields(elt_pkg::OPC_DEC, LatMin, 0, elt_pkg::PH_FIRED, 0, 1, 0);

    idle_pct = 0;  stall_pct = 0;  run_random(260);
    idle_pct = 83; stall_pct = 0;  run_random(250);
    idle_pct = 0;  stall_pct = 83; run_random(250);
    idle_pct = 23; stall_pct = 23; run_random(270);
    in_valid_i <= 1'b0;

    while (checker_h.expected_updates.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (checker_h.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
